// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Operation and status codes, cell command encoding and default sizes.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int ENTRY_BITS_DEFAULT = 32;

    // Position width inside the cell row, wide enough for the largest depth
    localparam int POS_W = 12;

    // Item field widths on the stream ports
    localparam int KIND_W     = 2;
    localparam int POSITION_W = 7;
    localparam int SECOND_W   = 6;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SWAP   = 2'd2,
        KIND_GET    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BADPOS = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_LOAD   = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_WRITE2 = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
    } cell_cmd_t;

endpackage

// File: rtl/core/positional_list_engine.sv
// Insert executes straight from accept; get, remove and swap first read
// position p out through the cell row (one slot per cycle toward position
// zero), swap both positions in turn. Errors go straight to the result.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset clears the count and control; the entry
// cells are not cleared and hold nothing valid until written.
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list with insert, remove, swap and get
// A row of cells holds the entries; a small sequencer drives the row and
// returns one result item per input item.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_BITS = ple_pkg::ENTRY_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position [6:0], second_position [12:7], entry_word [44:13], zero fill
    input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [ple_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_out [31:0], status [33:32], entry_count [40:34], zero fill
    output logic [ple_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ple_pkg::POS_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    ple_pkg::kind_t          kind_reg;
    logic [IDX_W-1:0]        pos_a_reg;
    logic [IDX_W-1:0]        pos_b_reg;
    logic [IDX_W-1:0]        rd_cnt_reg;
    logic                    second_reg;
    logic [ENTRY_BITS-1:0]   word_reg;
    logic [ENTRY_BITS-1:0]   held_reg;
    logic [ENTRY_BITS-1:0]   res_entry_reg;
    ple_pkg::status_t        res_status_reg;
    logic                    m_tvalid_reg;
    logic [ple_pkg::WORD_W-1:0]   out_entry_reg;
    ple_pkg::status_t             out_status_reg;
    logic [ple_pkg::COUNT_W-1:0]  out_count_reg;

    logic [ple_pkg::POSITION_W-1:0] in_pos;
    logic [ple_pkg::SECOND_W-1:0]   in_sec;
    logic [ple_pkg::WORD_W-1:0]     in_word;
    ple_pkg::kind_t                 in_kind;
    logic [CMP_W-1:0]               p1_c;
    logic [CMP_W-1:0]               p2_c;
    logic [CMP_W-1:0]               cnt_c;
    ple_pkg::status_t               chk_status;
    logic                           accept;

    ple_pkg::cell_cmd_t      cmd;
    logic [ENTRY_BITS-1:0]   word_a;
    logic [ENTRY_BITS-1:0]   word_b;
    logic [ENTRY_BITS-1:0]   cell_data [DEPTH];
    logic [ENTRY_BITS-1:0]   cell_rd   [DEPTH];

    assign in_pos  = s_tdata[6:0];
    assign in_sec  = s_tdata[12:7];
    assign in_word = s_tdata[44:13];
    assign in_kind = ple_pkg::kind_t'(s_tuser);

    assign p1_c  = CMP_W'(in_pos);
    assign p2_c  = CMP_W'(in_sec);
    assign cnt_c = CMP_W'(count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        chk_status = ple_pkg::STATUS_OK;
        unique case (in_kind)
            ple_pkg::KIND_INSERT:
            begin
                if (p1_c > cnt_c)
                begin
                    chk_status = ple_pkg::STATUS_BADPOS;
                end
                else if (cnt_c == CMP_W'(DEPTH))
                begin
                    chk_status = ple_pkg::STATUS_FULL;
                end
            end
            ple_pkg::KIND_REMOVE, ple_pkg::KIND_GET:
            begin
                if (p1_c >= cnt_c)
                begin
                    chk_status = ple_pkg::STATUS_BADPOS;
                end
            end
            ple_pkg::KIND_SWAP:
            begin
                if ((p1_c >= cnt_c) || (p2_c >= cnt_c))
                begin
                    chk_status = ple_pkg::STATUS_BADPOS;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Drive the cell row from the sequencer state
    always_comb
    begin
        cmd.op    = ple_pkg::CELL_HOLD;
        cmd.pos_a = ple_pkg::POS_W'(pos_a_reg);
        cmd.pos_b = ple_pkg::POS_W'(pos_b_reg);
        word_a    = word_reg;
        word_b    = held_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.op = ple_pkg::CELL_LOAD;
            end
            ST_EXEC:
            begin
                unique case (kind_reg)
                    ple_pkg::KIND_INSERT: cmd.op = ple_pkg::CELL_INSERT;
                    ple_pkg::KIND_REMOVE: cmd.op = ple_pkg::CELL_REMOVE;
                    ple_pkg::KIND_SWAP:   cmd.op = ple_pkg::CELL_WRITE2;
                    default:              cmd.op = ple_pkg::CELL_HOLD;
                endcase
            end
            default:
            begin
                cmd.op = ple_pkg::CELL_HOLD;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ENTRY_BITS-1:0] lower_data;
        logic [ENTRY_BITS-1:0] upper_data;
        logic [ENTRY_BITS-1:0] upper_rd;

        if (i == 0)
        begin : g_first
            assign lower_data = '0;
        end
        else
        begin : g_mid_lo
            assign lower_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_data = '0;
            assign upper_rd   = '0;
        end
        else
        begin : g_mid_hi
            assign upper_data = cell_data[i+1];
            assign upper_rd   = cell_rd[i+1];
        end

        ple_cell #(
            .ENTRY_BITS (ENTRY_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .word_a     (word_a),
            .word_b     (word_b),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .upper_rd   (upper_rd),
            .data       (cell_data[i]),
            .rd         (cell_rd[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            kind_reg       <= ple_pkg::KIND_INSERT;
            pos_a_reg      <= '0;
            pos_b_reg      <= '0;
            rd_cnt_reg     <= '0;
            second_reg     <= 1'b0;
            word_reg       <= '0;
            held_reg       <= '0;
            res_entry_reg  <= '0;
            res_status_reg <= ple_pkg::STATUS_OK;
            m_tvalid_reg   <= 1'b0;
            out_entry_reg  <= '0;
            out_status_reg <= ple_pkg::STATUS_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg       <= in_kind;
                        pos_a_reg      <= IDX_W'(in_pos);
                        pos_b_reg      <= IDX_W'(in_sec);
                        rd_cnt_reg     <= IDX_W'(in_pos);
                        word_reg       <= ENTRY_BITS'(in_word);
                        second_reg     <= 1'b0;
                        res_entry_reg  <= '0;
                        res_status_reg <= chk_status;
                        if (chk_status != ple_pkg::STATUS_OK)
                        begin
                            state_reg <= ST_RESP;
                        end
                        else if (in_kind == ple_pkg::KIND_INSERT)
                        begin
                            state_reg <= ST_EXEC;
                        end
                        else
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    if (rd_cnt_reg != '0)
                    begin
                        rd_cnt_reg <= rd_cnt_reg - IDX_W'(1);
                    end
                    else
                    begin
                        unique case (kind_reg)
                            ple_pkg::KIND_GET:
                            begin
                                res_entry_reg <= cell_rd[0];
                                state_reg     <= ST_RESP;
                            end
                            ple_pkg::KIND_REMOVE:
                            begin
                                res_entry_reg <= cell_rd[0];
                                state_reg     <= ST_EXEC;
                            end
                            ple_pkg::KIND_SWAP:
                            begin
                                if (!second_reg)
                                begin
                                    // hold first word, go read the second position
                                    held_reg   <= cell_rd[0];
                                    second_reg <= 1'b1;
                                    rd_cnt_reg <= pos_b_reg;
                                    state_reg  <= ST_LOAD;
                                end
                                else
                                begin
                                    word_reg  <= cell_rd[0];
                                    state_reg <= ST_EXEC;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_EXEC:
                begin
                    if (kind_reg == ple_pkg::KIND_INSERT)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else if (kind_reg == ple_pkg::KIND_REMOVE)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_entry_reg  <= ple_pkg::WORD_W'(res_entry_reg);
                        out_status_reg <= res_status_reg;
                        out_count_reg  <= ple_pkg::COUNT_W'(count_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_count_reg, out_status_reg, out_entry_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (out_status_reg != ple_pkg::STATUS_OK)) |-> (out_entry_reg == '0))
        else $error("error result carries an entry");

    a_count_exec_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EXEC) |=> (count_reg == $past(count_reg)))
        else $error("count changed outside execute step");

    a_full_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && kind_reg == ple_pkg::KIND_INSERT)
            |-> (count_reg != CNT_W'(DEPTH)))
        else $error("insert executed into a full list");

endmodule

// File: rtl/core/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one list slot of the positional list engine
// Holds one entry, shifts toward its neighbors on insert and remove, takes
// broadcast writes for swap, and passes a read word down the row.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int ENTRY_BITS = ple_pkg::ENTRY_BITS_DEFAULT,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  ple_pkg::cell_cmd_t    cmd,
    input  logic [ENTRY_BITS-1:0] word_a,
    input  logic [ENTRY_BITS-1:0] word_b,
    input  logic [ENTRY_BITS-1:0] lower_data,
    input  logic [ENTRY_BITS-1:0] upper_data,
    input  logic [ENTRY_BITS-1:0] upper_rd,
    output logic [ENTRY_BITS-1:0] data,
    output logic [ENTRY_BITS-1:0] rd
);

    localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(INDEX);

    logic [ENTRY_BITS-1:0] data_reg;
    logic [ENTRY_BITS-1:0] data_next;
    logic [ENTRY_BITS-1:0] rd_reg;
    logic [ENTRY_BITS-1:0] rd_next;

    always_comb
    begin
        data_next = data_reg;
        // read word moves one slot toward position zero every cycle but a load
        rd_next   = upper_rd;
        unique case (cmd.op)
            ple_pkg::CELL_HOLD:
            begin
            end
            ple_pkg::CELL_LOAD:
            begin
                rd_next = data_reg;
            end
            ple_pkg::CELL_INSERT:
            begin
                if (MY_IDX > cmd.pos_a)
                begin
                    data_next = lower_data;
                end
                else if (MY_IDX == cmd.pos_a)
                begin
                    data_next = word_a;
                end
            end
            ple_pkg::CELL_REMOVE:
            begin
                if (MY_IDX >= cmd.pos_a)
                begin
                    data_next = upper_data;
                end
            end
            ple_pkg::CELL_WRITE2:
            begin
                if (MY_IDX == cmd.pos_a)
                begin
                    data_next = word_a;
                end
                else if (MY_IDX == cmd.pos_b)
                begin
                    data_next = word_b;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule
